// ===== hw/rtl/y86df_pkg.sv =====
// Shared types, constants and decode functions for the Y86-64 decode stage.
// Depends on nothing; included first by every other file of the block.
package y86df_pkg;

    localparam int          NumRegs  = 15;
    localparam logic [3:0]  RegNone  = 4'hF;
    localparam logic [3:0]  RegRsp   = 4'h4;

    // Instruction codes
    localparam logic [3:0]  OpRrmovq = 4'h2;
    localparam logic [3:0]  OpIrmovq = 4'h3;
    localparam logic [3:0]  OpRmmovq = 4'h4;
    localparam logic [3:0]  OpMrmovq = 4'h5;
    localparam logic [3:0]  OpOpq    = 4'h6;
    localparam logic [3:0]  OpJxx    = 4'h7;
    localparam logic [3:0]  OpCall   = 4'h8;
    localparam logic [3:0]  OpRet    = 4'h9;
    localparam logic [3:0]  OpPushq  = 4'hA;
    localparam logic [3:0]  OpPopq   = 4'hB;

    localparam int InWidth  = 488;
    localparam int OutWidth = 216;

    // Input item, first field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [63:0] wb_value_e;
        logic [63:0] wb_value_m;
        logic [7:0]  wb_dests;
        logic [63:0] mem_value_e;
        logic [63:0] mem_value_m;
        logic [7:0]  mem_dests;
        logic [63:0] ex_value_e;
        logic [3:0]  ex_dest_e;
        logic [63:0] next_pc;
        logic [63:0] const_word;
        logic [7:0]  reg_byte;
        logic [7:0]  instr_byte;
    } in_item_t;

    // Result item, first field in the lowest bits
    typedef struct packed {
        logic [3:0]  source_b;
        logic [3:0]  source_a;
        logic [3:0]  dest_m;
        logic [3:0]  dest_e;
        logic [63:0] operand_b;
        logic [63:0] operand_a;
        logic [63:0] out_const;
        logic [3:0]  out_ifun;
        logic [3:0]  out_icode;
    } out_item_t;

    // Forwarding sources of the later pipeline stages
    typedef struct packed {
        logic [3:0]  e_dst;
        logic [63:0] e_val;
        logic [3:0]  m_dste;
        logic [3:0]  m_dstm;
        logic [63:0] m_valm;
        logic [63:0] m_vale;
        logic [3:0]  w_dste;
        logic [3:0]  w_dstm;
        logic [63:0] w_valm;
        logic [63:0] w_vale;
    } fwd_t;

    function automatic logic [3:0] pick_src_a(input logic [3:0] op, input logic [3:0] ra);
        logic [3:0] r;
        r = RegNone;
        case (op) inside
            OpRrmovq, OpRmmovq, OpOpq, OpPushq: r = ra;
            OpPopq, OpRet:                      r = RegRsp;
            default:                            r = RegNone;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pick_src_b(input logic [3:0] op, input logic [3:0] rb);
        logic [3:0] r;
        r = RegNone;
        case (op) inside
            OpOpq, OpRmmovq, OpMrmovq:          r = rb;
            OpPushq, OpPopq, OpCall, OpRet:     r = RegRsp;
            default:                            r = RegNone;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pick_dst_e(input logic [3:0] op, input logic [3:0] rb);
        logic [3:0] r;
        r = RegNone;
        case (op) inside
            OpRrmovq, OpIrmovq, OpOpq:          r = rb;
            OpPushq, OpPopq, OpCall, OpRet:     r = RegRsp;
            default:                            r = RegNone;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pick_dst_m(input logic [3:0] op, input logic [3:0] ra);
        logic [3:0] r;
        r = RegNone;
        case (op) inside
            OpMrmovq, OpPopq:                   r = ra;
            default:                            r = RegNone;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/y86df_regfile.sv =====
// Fifteen-entry register file: one bank per writeback port, a newest-bank flag
// and a valid flag per entry. Depends on y86df_pkg.
module y86df_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [3:0]  rd_addr_a,
    input  logic [3:0]  rd_addr_b,
    input  logic        wr_en,
    input  logic [3:0]  wr_idx_e,
    input  logic [63:0] wr_val_e,
    input  logic [3:0]  wr_idx_m,
    input  logic [63:0] wr_val_m,
    output logic [63:0] rd_val_a,
    output logic [63:0] rd_val_b
);
    import y86df_pkg::*;

    logic [63:0]        bank_e [NumRegs];
    logic [63:0]        bank_m [NumRegs];
    logic [NumRegs-1:0] valid_reg;
    logic [NumRegs-1:0] valid_next;
    logic [NumRegs-1:0] sel_m_reg;
    logic [NumRegs-1:0] sel_m_next;

    logic [63:0] rd_e_a_reg, rd_m_a_reg, rd_e_b_reg, rd_m_b_reg;
    logic        vld_a_reg, vld_b_reg, sel_a_reg, sel_b_reg;

    // E bank: written by W valE
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_idx_e != RegNone)
        begin
            bank_e[wr_idx_e] <= wr_val_e;
        end
        if (rd_en)
        begin
            rd_e_a_reg <= bank_e[rd_addr_a];
            rd_e_b_reg <= bank_e[rd_addr_b];
        end
    end

    // M bank: written by W valM
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_idx_m != RegNone)
        begin
            bank_m[wr_idx_m] <= wr_val_m;
        end
        if (rd_en)
        begin
            rd_m_a_reg <= bank_m[rd_addr_a];
            rd_m_b_reg <= bank_m[rd_addr_b];
        end
    end

    // Per-entry flags; valM wins when both ports hit the same entry
    always_comb
    begin
        valid_next = valid_reg;
        sel_m_next = sel_m_reg;
        for (int i = 0; i < NumRegs; i++)
        begin
            if (wr_en && wr_idx_m == 4'(i))
            begin
                valid_next[i] = 1'b1;
                sel_m_next[i] = 1'b1;
            end
            else if (wr_en && wr_idx_e == 4'(i))
            begin
                valid_next[i] = 1'b1;
                sel_m_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            sel_m_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            sel_a_reg <= 1'b0;
            sel_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_m_reg <= sel_m_next;
            if (rd_en)
            begin
                // flags sampled before this item's own writes
                vld_a_reg <= (rd_addr_a != RegNone) && valid_reg[rd_addr_a];
                vld_b_reg <= (rd_addr_b != RegNone) && valid_reg[rd_addr_b];
                sel_a_reg <= (rd_addr_a != RegNone) && sel_m_reg[rd_addr_a];
                sel_b_reg <= (rd_addr_b != RegNone) && sel_m_reg[rd_addr_b];
            end
        end
    end

    // Unwritten entries read as zero
    assign rd_val_a = !vld_a_reg ? 64'd0 : (sel_a_reg ? rd_m_a_reg : rd_e_a_reg);
    assign rd_val_b = !vld_b_reg ? 64'd0 : (sel_b_reg ? rd_m_b_reg : rd_e_b_reg);

endmodule

// ===== hw/rtl/y86df_fwd_sel.sv =====
// Operand forwarding mux for one source register.
// Depends on y86df_pkg.
module y86df_fwd_sel (
    input  logic [3:0]       src,
    input  y86df_pkg::fwd_t  fwd,
    input  logic [63:0]      rf_val,
    output logic [63:0]      val
);
    import y86df_pkg::*;

    // Priority: e_dstE, M dstM, M dstE, W dstM, W dstE, register file
    always_comb
    begin
        if (src == RegNone)
            val = 64'd0;
        else if (src == fwd.e_dst)
            val = fwd.e_val;
        else if (src == fwd.m_dstm)
            val = fwd.m_valm;
        else if (src == fwd.m_dste)
            val = fwd.m_vale;
        else if (src == fwd.w_dstm)
            val = fwd.w_valm;
        else if (src == fwd.w_dste)
            val = fwd.w_vale;
        else
            val = rf_val;
    end

endmodule

// ===== hw/rtl/y86_decode_operand_forwarding.sv =====
// Top level of the Y86-64 decode stage with operand forwarding.
// Depends on y86df_pkg, y86df_regfile and y86df_fwd_sel.

// Takes one instruction item per clock while the output is not stalled and returns one
// result item per item through the stage register and the result register. At acceptance the
// register indexes are decoded and the register file is read into the stage
// register; in the same edge the item's writeback (W valE, then W valM) is
// written, so the next item sees it. The next cycle forwarding picks each
// operand and the result register holds the item until taken. The register
// file is all zero after reset with no clearing pass.
module y86_decode_operand_forwarding (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instr_byte, reg_byte, const_word, next_pc, ex_dest_e, ex_value_e,
    // mem_dests, mem_value_m, mem_value_e, wb_dests, wb_value_m, wb_value_e, pad
    input  logic [487:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_icode, out_ifun, out_const, operand_a, operand_b,
    // dest_e, dest_m, source_a, source_b
    output logic [215:0] m_tdata
);
    import y86df_pkg::*;

    in_item_t  in_item;
    out_item_t res_next;
    out_item_t res_reg;
    fwd_t      fwd_in;

    logic        s1_valid_reg;
    logic        m_valid_reg;
    logic        in_fire;
    logic        advance;
    logic [3:0]  in_src_a, in_src_b;

    logic [3:0]  s1_icode_reg, s1_ifun_reg;
    logic [63:0] s1_const_reg, s1_pc_reg;
    logic [3:0]  s1_src_a_reg, s1_src_b_reg, s1_dst_e_reg, s1_dst_m_reg;
    fwd_t        s1_fwd_reg;

    logic [63:0] rf_a, rf_b, fwd_a, fwd_b;

    assign in_item = in_item_t'(s_tdata);

    // Handshake: stage register moves when the result register frees up
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    // Source decode at the input for the register file read
    assign in_src_a = pick_src_a(in_item.instr_byte[7:4], in_item.reg_byte[7:4]);
    assign in_src_b = pick_src_b(in_item.instr_byte[7:4], in_item.reg_byte[3:0]);

    always_comb
    begin
        fwd_in.e_dst  = in_item.ex_dest_e;
        fwd_in.e_val  = in_item.ex_value_e;
        fwd_in.m_dste = in_item.mem_dests[7:4];
        fwd_in.m_dstm = in_item.mem_dests[3:0];
        fwd_in.m_valm = in_item.mem_value_m;
        fwd_in.m_vale = in_item.mem_value_e;
        fwd_in.w_dste = in_item.wb_dests[7:4];
        fwd_in.w_dstm = in_item.wb_dests[3:0];
        fwd_in.w_valm = in_item.wb_value_m;
        fwd_in.w_vale = in_item.wb_value_e;
    end

    y86df_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_addr_a (in_src_a),
        .rd_addr_b (in_src_b),
        .wr_en     (in_fire),
        .wr_idx_e  (in_item.wb_dests[7:4]),
        .wr_val_e  (in_item.wb_value_e),
        .wr_idx_m  (in_item.wb_dests[3:0]),
        .wr_val_m  (in_item.wb_value_m),
        .rd_val_a  (rf_a),
        .rd_val_b  (rf_b)
    );

    // Stage register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_icode_reg <= in_item.instr_byte[7:4];
            s1_ifun_reg  <= in_item.instr_byte[3:0];
            s1_const_reg <= in_item.const_word;
            s1_pc_reg    <= in_item.next_pc;
            s1_src_a_reg <= in_src_a;
            s1_src_b_reg <= in_src_b;
            s1_dst_e_reg <= pick_dst_e(in_item.instr_byte[7:4], in_item.reg_byte[3:0]);
            s1_dst_m_reg <= pick_dst_m(in_item.instr_byte[7:4], in_item.reg_byte[7:4]);
            s1_fwd_reg   <= fwd_in;
        end
    end

    y86df_fwd_sel u_fwd_a (
        .src    (s1_src_a_reg),
        .fwd    (s1_fwd_reg),
        .rf_val (rf_a),
        .val    (fwd_a)
    );

    y86df_fwd_sel u_fwd_b (
        .src    (s1_src_b_reg),
        .fwd    (s1_fwd_reg),
        .rf_val (rf_b),
        .val    (fwd_b)
    );

    // Result assembly; call and jump carry valP as valA
    always_comb
    begin
        res_next.out_icode = s1_icode_reg;
        res_next.out_ifun  = s1_ifun_reg;
        res_next.out_const = s1_const_reg;
        res_next.operand_a = (s1_icode_reg == OpCall || s1_icode_reg == OpJxx) ?
                             s1_pc_reg : fwd_a;
        res_next.operand_b = fwd_b;
        res_next.dest_e    = s1_dst_e_reg;
        res_next.dest_m    = s1_dst_m_reg;
        res_next.source_a  = s1_src_a_reg;
        res_next.source_b  = s1_src_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            res_reg <= res_next;
        end
    end

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // Assertions
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("stage item dropped while output stalled");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> m_valid_reg)
        else $error("stage item not moved into result register");

    a_none_a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && res_reg.source_a == RegNone && res_reg.out_icode != OpCall
        && res_reg.out_icode != OpJxx |-> res_reg.operand_a == 64'd0)
        else $error("operand_a nonzero with no source");

    a_none_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && res_reg.source_b == RegNone |-> res_reg.operand_b == 64'd0)
        else $error("operand_b nonzero with no source");

    a_dest_m_ops: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && res_reg.dest_m != RegNone |->
        res_reg.out_icode == OpMrmovq || res_reg.out_icode == OpPopq)
        else $error("dest_m set for an instruction that loads nothing");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Y86-64 decode stage with operand forwarding.
// Depends on y86df_pkg for the item layouts and codes; drives y86_decode_operand_forwarding.
`timescale 1ns / 100ps

module tb;

    import y86df_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;
    localparam int PhaseItems    = 344;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [487:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;

    // Predicted decode results, oldest first
    out_item_t    decoded_q[$];
    // Architectural register file as seen by the decode stage
    logic [63:0]  gpr[NumRegs];
    int           errors         = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           quiet_cycles   = 0;

    y86_decode_operand_forwarding dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Operand value: pipeline bypass in priority order, else register file
    function automatic logic [63:0] fwd_operand(input logic [3:0] src, input in_item_t it);
        if (src == RegNone)            return '0;
        if (src == it.ex_dest_e)       return it.ex_value_e;
        if (src == it.mem_dests[3:0])  return it.mem_value_m;
        if (src == it.mem_dests[7:4])  return it.mem_value_e;
        if (src == it.wb_dests[3:0])   return it.wb_value_m;
        if (src == it.wb_dests[7:4])   return it.wb_value_e;
        return gpr[src];
    endfunction

    // Decode one instruction, then apply its writeback (valE first, valM wins)
    function automatic out_item_t decode_step(input in_item_t it);
        out_item_t  r;
        logic [3:0] op;
        logic [3:0] ra;
        logic [3:0] rb;
        op          = it.instr_byte[7:4];
        ra          = it.reg_byte[7:4];
        rb          = it.reg_byte[3:0];
        r.out_icode = op;
        r.out_ifun  = it.instr_byte[3:0];
        r.out_const = it.const_word;
        r.source_a  = RegNone;
        r.source_b  = RegNone;
        r.dest_e    = RegNone;
        r.dest_m    = RegNone;
        case (op)
            OpRrmovq:
            begin
                r.source_a = ra;
                r.dest_e   = rb;
            end
            OpIrmovq: r.dest_e = rb;
            OpRmmovq:
            begin
                r.source_a = ra;
                r.source_b = rb;
            end
            OpMrmovq:
            begin
                r.source_b = rb;
                r.dest_m   = ra;
            end
            OpOpq:
            begin
                r.source_a = ra;
                r.source_b = rb;
                r.dest_e   = rb;
            end
            OpCall:
            begin
                r.source_b = RegRsp;
                r.dest_e   = RegRsp;
            end
            OpRet:
            begin
                r.source_a = RegRsp;
                r.source_b = RegRsp;
                r.dest_e   = RegRsp;
            end
            OpPushq:
            begin
                r.source_a = ra;
                r.source_b = RegRsp;
                r.dest_e   = RegRsp;
            end
            OpPopq:
            begin
                r.source_a = RegRsp;
                r.source_b = RegRsp;
                r.dest_e   = RegRsp;
                r.dest_m   = ra;
            end
            default: ;
        endcase
        if (op == OpCall || op == OpJxx)
            r.operand_a = it.next_pc;
        else
            r.operand_a = fwd_operand(r.source_a, it);
        r.operand_b = fwd_operand(r.source_b, it);
        if (it.wb_dests[7:4] != RegNone)
            gpr[it.wb_dests[7:4]] = it.wb_value_e;
        if (it.wb_dests[3:0] != RegNone)
            gpr[it.wb_dests[3:0]] = it.wb_value_m;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Random content: mostly full-range, sometimes the extremes
    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Register indexes lean on a small pool (rsp included) so bypass hits are common
    function automatic logic [3:0] rand_reg();
        if ($urandom_range(3) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(5));
    endfunction

    function automatic logic [3:0] rand_dest();
        if ($urandom_range(9) < 4)
            return RegNone;
        return rand_reg();
    endfunction

    function automatic in_item_t rand_insn();
        in_item_t   it;
        logic [3:0] op;
        it = '0;
        if ($urandom_range(9) == 0)
            op = 4'($urandom_range(15));
        else
            op = 4'($urandom_range(11));
        it.instr_byte  = {op, 4'($urandom_range(15))};
        it.reg_byte    = {rand_reg(), rand_reg()};
        it.const_word  = rand_word();
        it.next_pc     = rand_word();
        it.ex_dest_e   = rand_dest();
        it.ex_value_e  = rand_word();
        it.mem_dests   = {rand_dest(), rand_dest()};
        it.mem_value_m = rand_word();
        it.mem_value_e = rand_word();
        it.wb_dests    = {rand_dest(), rand_dest()};
        it.wb_value_m  = rand_word();
        it.wb_value_e  = rand_word();
        return it;
    endfunction

    // Random item with every bypass source and writeback set to none
    function automatic in_item_t quiet_insn();
        in_item_t it;
        it           = rand_insn();
        it.ex_dest_e = RegNone;
        it.mem_dests = {RegNone, RegNone};
        it.wb_dests  = {RegNone, RegNone};
        return it;
    endfunction

    // Present one item from a falling edge and hold it until accepted
    task automatic send_insn(input in_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = it;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Every icode including unknown ones, register bytes and words at extremes
    task automatic test_opcode_decode();
        in_item_t it;
        for (int op = 0; op < 16; op++)
        begin
            it            = quiet_insn();
            it.instr_byte = {4'(op), (op == 0) ? 4'h0 : (op == 15) ? 4'hF : 4'($urandom_range(15))};
            case (op % 3)
                0:       it.reg_byte = 8'h00;
                1:       it.reg_byte = 8'hFF;
                default: it.reg_byte = {4'($urandom_range(14)), 4'($urandom_range(14))};
            endcase
            it.const_word = (op % 2) ? '1 : '0;
            it.next_pc    = (op % 2) ? '0 : '1;
            send_insn(it);
        end
    endtask

    // Bypass priority on one register, then register file reads and none sources
    task automatic test_forwarding_priority();
        in_item_t it;
        // Every stage targets r3: execute wins
        it             = quiet_insn();
        it.instr_byte  = {OpOpq, 4'h0};
        it.reg_byte    = 8'h33;
        it.ex_dest_e   = 4'h3;
        it.mem_dests   = 8'h33;
        it.wb_dests    = 8'h33;
        send_insn(it);
        // Memory valM over memory valE and writeback
        it.ex_dest_e   = RegNone;
        it.ex_value_e  = rand_word();
        send_insn(it);
        // Memory valE alone
        it.mem_dests   = {4'h3, RegNone};
        send_insn(it);
        // Writeback valM over valE; same index also checks write order
        it.mem_dests   = {RegNone, RegNone};
        it.wb_value_m  = 64'hA5A5_5A5A_0123_4567;
        it.wb_value_e  = 64'h5A5A_A5A5_89AB_CDEF;
        send_insn(it);
        // Writeback valE alone, into r5 so r3 keeps the valM above
        it.wb_dests    = {4'h3, RegNone};
        it.reg_byte    = 8'h35;
        it.wb_dests    = {4'h5, RegNone};
        send_insn(it);
        // No bypass hit: r3 and r5 come from the register file
        it             = quiet_insn();
        it.instr_byte  = {OpRmmovq, 4'h0};
        it.reg_byte    = 8'h35;
        send_insn(it);
        // Source none in a used slot is zero even when stages name register 15
        it             = quiet_insn();
        it.instr_byte  = {OpPushq, 4'h0};
        it.reg_byte    = 8'hFF;
        it.ex_dest_e   = 4'hF;
        send_insn(it);
        // Call and jump take valP even with rsp bypassed
        it             = quiet_insn();
        it.instr_byte  = {OpCall, 4'h0};
        it.ex_dest_e   = RegRsp;
        send_insn(it);
        it.instr_byte  = {OpJxx, 4'h3};
        send_insn(it);
    endtask

    task automatic test_random_stream(input int n, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n)
            send_insn(rand_insn());
    endtask

    // Backpressure on the result side
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_stall_pct);

    // Prediction on input acceptance, comparison on result acceptance, watchdog
    always @(posedge clk)
    begin : scoreboard
        out_item_t exp_r;
        out_item_t got_r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_step(in_item_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                got_r = m_tdata;
                if (decoded_q.size() == 0)
                begin
                    $error("result item with no instruction outstanding");
                    errors++;
                end
                else
                begin
                    exp_r = decoded_q.pop_front();
                    check_field("out_icode", 64'(exp_r.out_icode), 64'(got_r.out_icode));
                    check_field("out_ifun",  64'(exp_r.out_ifun),  64'(got_r.out_ifun));
                    check_field("out_const", exp_r.out_const, got_r.out_const);
                    check_field("operand_a", exp_r.operand_a, got_r.operand_a);
                    check_field("operand_b", exp_r.operand_b, got_r.operand_b);
                    check_field("dest_e",    64'(exp_r.dest_e),    64'(got_r.dest_e));
                    check_field("dest_m",    64'(exp_r.dest_m),    64'(got_r.dest_m));
                    check_field("source_a",  64'(exp_r.source_a),  64'(got_r.source_a));
                    check_field("source_b",  64'(exp_r.source_b),  64'(got_r.source_b));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NumRegs; i++)
            gpr[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_opcode_decode();
        test_forwarding_priority();
        test_random_stream(PhaseItems, 0, 0);
        test_random_stream(PhaseItems, 52, 0);
        test_random_stream(PhaseItems, 0, 52);
        test_random_stream(PhaseItems, 16, 16);

        // Drain
        s_tvalid       = 1'b0;
        sink_stall_pct = 0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/y86df_pkg.sv
hw/rtl/y86df_regfile.sv
hw/rtl/y86df_fwd_sel.sv
hw/rtl/y86_decode_operand_forwarding.sv
dv/tb.sv
